// ===== design/aec_pkg.sv =====
`default_nettype none
package aec_pkg;

    localparam int RAD_BITS = 11;
    localparam int QX = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int COLOR_BITS = 32;
    localparam int ALPHA_BITS = 8;
    localparam logic [COLOR_BITS-1:0] COLOR_MASK = 32'hffffff00;
    localparam logic [ALPHA_BITS-1:0] ALPHA_FULL = 8'hff;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_RADIUS_X    = 3'd2,
        CFG_RADIUS_Y    = 3'd3,
        CFG_RING_THICK  = 3'd4,
        CFG_FILLED_MODE = 3'd5,
        CFG_DRAW_COLOR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic live;
    } t_ctl;

endpackage
`default_nettype wire

// ===== design/antialiased_ellipse_coverage.sv =====
// throughput: one pixel per cycle while the pipe advances; divider, square root and multiply stages all pipelined
// the whole pipe advances when the result register is empty or being taken
// reset (synchronous, active low) empties the pipe and loads the register defaults
`default_nettype none
module antialiased_ellipse_coverage #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel_x, pixel_y, clip_left, clip_right, clip_top, clip_bottom
    input  wire [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // draw_pixel, coverage_alpha, pixel_color
    output logic [47:0]                           m_axis_tdata,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [aec_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire [aec_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import aec_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int ONE  = 1 << FB;
    localparam int DXW  = CB + 1;
    localparam int HSW  = CB + 2;
    localparam int HW   = 2 * CB + 2;
    localparam int SW   = HW + 1;
    localparam int DW   = 2 * RAD_BITS + 2;
    localparam int QB   = FB + QX;
    localparam int QSW  = QB + 1;
    localparam int RIW  = QSW + FB;
    localparam int RW   = RIW / 2;
    localparam int FIW  = SW + 2 * FB - 1;
    localparam int FSW  = FIW / 2;
    localparam int GW   = RW + RAD_BITS + 2;
    localparam int MW   = GW - 1;
    localparam int PW   = 2 * MW;
    localparam int EW   = FB + 1;
    localparam int FPW  = EW + FSW;
    localparam int AW   = FPW - FB + 1;
    localparam int CW   = ((DXW > RAD_BITS + 1) ? DXW : RAD_BITS + 1) + 2;
    localparam int XW   = ((HW > DW + QX) ? HW : DW + QX) + 1;
    localparam int OTW  = 48;

    logic signed [CB-1:0]       r_center_x, r_center_y;
    logic [RAD_BITS-1:0]        r_radius_x, r_radius_y, r_ring_thick;
    logic                       r_filled;
    logic [COLOR_BITS-1:0]      r_draw_color;

    logic [DW-1:0]              r_rr_ox, r_rr_oy, r_rr_ix, r_rr_iy;
    logic [RAD_BITS-1:0]        r_ai;
    logic                       r_in_ok;
    logic signed [RAD_BITS:0]   w_ai, w_bi;

    logic                       w_en;

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_radius_x   <= RAD_BITS'(1);
            r_radius_y   <= RAD_BITS'(1);
            r_ring_thick <= RAD_BITS'(1);
            r_filled     <= 1'b0;
            r_draw_color <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X:    r_center_x   <= i_cfg_data[CB-1:0];
                CFG_CENTER_Y:    r_center_y   <= i_cfg_data[CB-1:0];
                CFG_RADIUS_X:    r_radius_x   <= i_cfg_data[RAD_BITS-1:0];
                CFG_RADIUS_Y:    r_radius_y   <= i_cfg_data[RAD_BITS-1:0];
                CFG_RING_THICK:  r_ring_thick <= i_cfg_data[RAD_BITS-1:0];
                CFG_FILLED_MODE: r_filled     <= i_cfg_data[0];
                CFG_DRAW_COLOR:  r_draw_color <= i_cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // radius derived constants
    assign w_ai = $signed({1'b0, r_radius_x}) - $signed({1'b0, r_ring_thick});
    assign w_bi = $signed({1'b0, r_radius_y}) - $signed({1'b0, r_ring_thick});

    always_ff @(posedge i_clk) begin
        r_rr_ox <= (DW'(r_radius_x) * DW'(r_radius_x)) << 2;
        r_rr_oy <= (DW'(r_radius_y) * DW'(r_radius_y)) << 2;
        r_rr_ix <= (DW'(w_ai[RAD_BITS-1:0]) * DW'(w_ai[RAD_BITS-1:0])) << 2;
        r_rr_iy <= (DW'(w_bi[RAD_BITS-1:0]) * DW'(w_bi[RAD_BITS-1:0])) << 2;
        r_ai    <= w_ai[RAD_BITS-1:0];
        r_in_ok <= (w_ai > 0) && (w_bi > 0);
    end

    // stage 1: offsets, clip and box tests
    logic signed [CB-1:0]  w_px, w_py, w_cl, w_cr, w_ct, w_cb;
    logic signed [DXW-1:0] w_dx, w_dy;
    logic signed [CW-1:0]  w_dxc, w_dyc, w_rxc, w_ryc;
    logic                  w_clip, w_boxf, w_boxr, w_live;
    t_ctl                  r_s1_ctl;
    logic signed [HSW-1:0] r_s1_hx, r_s1_hy;

    assign w_px = s_axis_tdata[0*CB +: CB];
    assign w_py = s_axis_tdata[1*CB +: CB];
    assign w_cl = s_axis_tdata[2*CB +: CB];
    assign w_cr = s_axis_tdata[3*CB +: CB];
    assign w_ct = s_axis_tdata[4*CB +: CB];
    assign w_cb = s_axis_tdata[5*CB +: CB];

    assign w_dx  = DXW'(w_px) - DXW'(r_center_x);
    assign w_dy  = DXW'(w_py) - DXW'(r_center_y);
    assign w_dxc = CW'(w_dx);
    assign w_dyc = CW'(w_dy);
    assign w_rxc = CW'($signed({1'b0, r_radius_x}));
    assign w_ryc = CW'($signed({1'b0, r_radius_y}));

    assign w_clip = (w_px >= w_cl) && (w_px <= w_cr) && (w_py >= w_ct) && (w_py <= w_cb);
    assign w_boxf = (w_dxc >= -w_rxc) && (w_dxc < w_rxc) &&
                    (w_dyc >= -w_ryc) && (w_dyc < w_ryc);
    assign w_boxr = (w_dxc >= -w_rxc - CW'(1)) && (w_dxc < w_rxc + CW'(1)) &&
                    (w_dyc >= -w_ryc - CW'(1)) && (w_dyc < w_ryc + CW'(1));
    assign w_live = w_clip && (r_radius_x != '0) && (r_radius_y != '0) &&
                    (r_filled ? w_boxf : w_boxr);

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_hx <= {w_dx, 1'b1};
            r_s1_hy <= {w_dy, 1'b1};
        end
    end

    // stage 2: squares
    t_ctl          r_s2_ctl;
    logic [HW-1:0] r_s2_hhx, r_s2_hhy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_hhx <= HW'(r_s1_hx) * HW'(r_s1_hx);
            r_s2_hhy <= HW'(r_s1_hy) * HW'(r_s1_hy);
        end
    end

    // stage 3: range checks and distance sum
    t_ctl          r_s3_ctl;
    logic [HW-1:0] r_s3_hhx, r_s3_hhy;
    logic [SW-1:0] r_s3_s;
    logic          r_s3_sox, r_s3_soy, r_s3_six, r_s3_siy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_hhx <= r_s2_hhx;
            r_s3_hhy <= r_s2_hhy;
            r_s3_s   <= SW'(r_s2_hhx) + SW'(r_s2_hhy);
            r_s3_sox <= XW'(r_s2_hhx) >= (XW'(r_rr_ox) << QX);
            r_s3_soy <= XW'(r_s2_hhy) >= (XW'(r_rr_oy) << QX);
            r_s3_six <= XW'(r_s2_hhx) >= (XW'(r_rr_ix) << QX);
            r_s3_siy <= XW'(r_s2_hhy) >= (XW'(r_rr_iy) << QX);
        end
    end

    // normalized terms
    logic [QB-1:0] w_q_ox, w_q_oy, w_q_ix, w_q_iy;
    logic [QB-1:0] w_nl_x, w_nl_y;

    assign w_nl_x = {r_s3_hhx[QX-1:0], {FB{1'b0}}};
    assign w_nl_y = {r_s3_hhy[QX-1:0], {FB{1'b0}}};

    aec_div #(.DW(DW), .QB(QB)) u_div_ox (
        .i_clk(i_clk), .i_en(w_en),
        .i_rem0(r_s3_sox ? '0 : DW'(r_s3_hhx >> QX)), .i_nlow(w_nl_x),
        .i_sat(r_s3_sox), .i_den(r_rr_ox), .o_quo(w_q_ox));
    aec_div #(.DW(DW), .QB(QB)) u_div_oy (
        .i_clk(i_clk), .i_en(w_en),
        .i_rem0(r_s3_soy ? '0 : DW'(r_s3_hhy >> QX)), .i_nlow(w_nl_y),
        .i_sat(r_s3_soy), .i_den(r_rr_oy), .o_quo(w_q_oy));
    aec_div #(.DW(DW), .QB(QB)) u_div_ix (
        .i_clk(i_clk), .i_en(w_en),
        .i_rem0(r_s3_six ? '0 : DW'(r_s3_hhx >> QX)), .i_nlow(w_nl_x),
        .i_sat(r_s3_six), .i_den(r_rr_ix), .o_quo(w_q_ix));
    aec_div #(.DW(DW), .QB(QB)) u_div_iy (
        .i_clk(i_clk), .i_en(w_en),
        .i_rem0(r_s3_siy ? '0 : DW'(r_s3_hhy >> QX)), .i_nlow(w_nl_y),
        .i_sat(r_s3_siy), .i_den(r_rr_iy), .o_quo(w_q_iy));

    // stage 4: ellipse sums
    logic [QSW-1:0] r_s4_qo, r_s4_qi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_qo <= QSW'(w_q_ox) + QSW'(w_q_oy);
            r_s4_qi <= r_in_ok ? QSW'(w_q_ix) + QSW'(w_q_iy) : '0;
        end
    end

    // square roots, aligned to the longest one
    logic [SW-1:0]     w_s_al;
    logic [RW-1:0]     w_dout_r, w_din_r, w_dout, w_din;
    logic [FSW-1:0]    w_wid;
    logic [QSW-1:0]    w_qo_al;
    logic [$bits(t_ctl)-1:0] w_ctl_al_raw;
    t_ctl              w_ctl_al;

    aec_dly #(.WIDTH(SW), .DEPTH(QB + 1)) u_dly_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_s3_s), .o_q(w_s_al));

    aec_sqrt #(.IW(RIW)) u_sqrt_out (
        .i_clk(i_clk), .i_en(w_en), .i_rad({r_s4_qo, {FB{1'b0}}}), .o_root(w_dout_r));
    aec_sqrt #(.IW(RIW)) u_sqrt_in (
        .i_clk(i_clk), .i_en(w_en), .i_rad({r_s4_qi, {FB{1'b0}}}), .o_root(w_din_r));
    aec_sqrt #(.IW(FIW)) u_sqrt_fill (
        .i_clk(i_clk), .i_en(w_en), .i_rad({1'b0, w_s_al, {(2*FB-2){1'b0}}}), .o_root(w_wid));

    aec_dly #(.WIDTH(2 * RW), .DEPTH(FSW - RW)) u_dly_root (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_d({w_dout_r, w_din_r}), .o_q({w_dout, w_din}));
    aec_dly #(.WIDTH(QSW), .DEPTH(FSW)) u_dly_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_s4_qo), .o_q(w_qo_al));
    aec_dly #(.WIDTH($bits(t_ctl)), .DEPTH(QB + 1 + FSW)) u_dly_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_d(r_s3_ctl), .o_q(w_ctl_al_raw));

    assign w_ctl_al = t_ctl'(w_ctl_al_raw);

    // c1: edge fades and filled product
    logic [RW-1:0]           w_dm;
    logic [RW+RAD_BITS-1:0]  w_fo_p;
    logic [FB+RAD_BITS-1:0]  w_fi_p;
    logic signed [GW-1:0]    w_fo_pe, w_fi_pe;
    logic [EW-1:0]           w_edge;
    t_ctl                    r_c1_ctl;
    logic signed [GW-1:0]    r_c1_fout, r_c1_fin;
    logic                    r_c1_din_lt, r_c1_q_ok;
    logic [FPW-1:0]          r_c1_fprod;

    assign w_dm    = w_dout - RW'(ONE);
    assign w_fo_p  = (RW+RAD_BITS)'(w_dm) * (RW+RAD_BITS)'(r_radius_x);
    assign w_fi_p  = (FB+RAD_BITS)'(FB'(RW'(ONE) - w_din)) * (FB+RAD_BITS)'(r_ai);
    assign w_fo_pe = GW'(w_fo_p);
    assign w_fi_pe = GW'(w_fi_p);
    assign w_edge  = EW'(QSW'(ONE) - w_qo_al);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_fout   <= (w_dout > RW'(ONE)) ? GW'(ONE) - w_fo_pe : GW'(ONE);
            r_c1_fin    <= (w_din != '0 && w_din < RW'(ONE)) ? GW'(ONE) - w_fi_pe : GW'(ONE);
            r_c1_din_lt <= w_din < RW'(ONE);
            r_c1_q_ok   <= w_qo_al <= QSW'(ONE);
            r_c1_fprod  <= FPW'(w_edge) * FPW'(w_wid);
        end
    end

    // c2: ring product
    logic [MW-1:0]        w_m1, w_m2;
    t_ctl                 r_c2_ctl;
    logic [PW-1:0]        r_c2_prod;
    logic                 r_c2_sgn_ok, r_c2_din_lt, r_c2_q_ok;
    logic signed [GW-1:0] r_c2_fout;
    logic [AW-1:0]        r_c2_a;

    assign w_m1 = r_c1_fout[GW-1] ? MW'(-r_c1_fout) : MW'(r_c1_fout);
    assign w_m2 = r_c1_fin[GW-1]  ? MW'(-r_c1_fin)  : MW'(r_c1_fin);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2_prod   <= PW'(w_m1) * PW'(w_m2);
            r_c2_sgn_ok <= r_c1_fout[GW-1] == r_c1_fin[GW-1];
            r_c2_din_lt <= r_c1_din_lt;
            r_c2_q_ok   <= r_c1_q_ok;
            r_c2_fout   <= r_c1_fout;
            r_c2_a      <= AW'(r_c1_fprod >> (FB - 1));
        end
    end

    // c3: coverage to alpha, result register
    logic [PW-FB-1:0]      w_pv;
    logic                  w_draw, w_full;
    logic [FB-1:0]         w_vlow;
    logic [FB+7:0]         w_scaled;
    logic                  r_out_valid, r_draw;
    logic [ALPHA_BITS-1:0] r_alpha;
    logic [COLOR_BITS-1:0] r_color;

    assign w_pv = r_c2_prod[PW-1:FB];

    always_comb begin
        if (r_filled) begin
            w_draw = r_c2_q_ok && (r_c2_a != '0);
            w_full = (r_c2_a >> FB) != '0;
            w_vlow = r_c2_a[FB-1:0];
        end else if (r_c2_din_lt) begin
            w_draw = r_c2_sgn_ok && (w_pv != '0);
            w_full = (w_pv >> FB) != '0;
            w_vlow = w_pv[FB-1:0];
        end else begin
            w_draw = !r_c2_fout[GW-1] && (r_c2_fout != '0);
            w_full = r_c2_fout >= GW'(ONE);
            w_vlow = r_c2_fout[FB-1:0];
        end
        w_draw = w_draw && r_c2_ctl.live;
    end

    assign w_scaled = {w_vlow, 8'b0} - (FB+8)'(w_vlow);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_draw  <= w_draw;
            r_alpha <= !w_draw ? '0 : (w_full ? ALPHA_FULL : w_scaled[FB+7:FB]);
            r_color <= r_draw_color & COLOR_MASK;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl    <= '0;
            r_s2_ctl    <= '0;
            r_s3_ctl    <= '0;
            r_c1_ctl    <= '0;
            r_c2_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_ctl    <= '{valid: s_axis_tvalid, live: w_live};
            r_s2_ctl    <= r_s1_ctl;
            r_s3_ctl    <= r_s2_ctl;
            r_c1_ctl    <= w_ctl_al;
            r_c2_ctl    <= r_c1_ctl;
            r_out_valid <= r_c2_ctl.valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OTW'({r_color, r_alpha, r_draw});

    a_no_draw_no_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == '0)
        else $error("alpha without draw");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_radius_x == '0 || r_radius_y == '0) |-> !m_axis_tdata[0])
        else $error("draw with zero radius");

    a_color_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:9] == '0)
        else $error("color low byte not cleared");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule
`default_nettype wire

// ===== design/aec_dly.sv =====
`default_nettype none
module aec_dly #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire [WIDTH-1:0]  i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_line[k] <= '0;
        end else if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[DEPTH-1];
endmodule
`default_nettype wire

// ===== design/aec_div.sv =====
`default_nettype none
module aec_div #(
    parameter int DW = 24,
    parameter int QB = 19
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire [DW-1:0]  i_rem0,
    input  wire [QB-1:0]  i_nlow,
    input  wire           i_sat,
    input  wire [DW-1:0]  i_den,
    output logic [QB-1:0] o_quo
);
    logic [DW-1:0] r_rem [QB];
    logic [QB-1:0] r_nl  [QB];
    logic [QB-1:0] r_q   [QB];
    logic          r_sat [QB];
    logic [DW-1:0] w_rem_in [QB];
    logic [QB-1:0] w_nl_in  [QB];
    logic [QB-1:0] w_q_in   [QB];
    logic          w_sat_in [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [DW:0] w_trial;
        logic        w_ge;
        if (s == 0) begin : g_first
            assign w_rem_in[s] = i_rem0;
            assign w_nl_in[s]  = i_nlow;
            assign w_q_in[s]   = '0;
            assign w_sat_in[s] = i_sat;
        end else begin : g_next
            assign w_rem_in[s] = r_rem[s-1];
            assign w_nl_in[s]  = r_nl[s-1];
            assign w_q_in[s]   = r_q[s-1];
            assign w_sat_in[s] = r_sat[s-1];
        end
        assign w_trial = {w_rem_in[s], w_nl_in[s][QB-1]};
        assign w_ge    = w_trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? DW'(w_trial - {1'b0, i_den}) : DW'(w_trial);
                r_nl[s]  <= w_nl_in[s] << 1;
                r_q[s]   <= {w_q_in[s][QB-2:0], w_ge};
                r_sat[s] <= w_sat_in[s];
            end
        end
    end

    assign o_quo = r_sat[QB-1] ? '1 : r_q[QB-1];
endmodule
`default_nettype wire

// ===== design/aec_sqrt.sv =====
`default_nettype none
module aec_sqrt #(
    parameter int IW = 36
) (
    input  wire             i_clk,
    input  wire             i_en,
    input  wire [IW-1:0]    i_rad,
    output logic [IW/2-1:0] o_root
);
    localparam int RTW = IW / 2;

    logic [RTW+1:0] r_rem  [RTW];
    logic [RTW-1:0] r_root [RTW];
    logic [IW-1:0]  r_rad  [RTW];
    logic [RTW+1:0] w_rem_in  [RTW];
    logic [RTW-1:0] w_root_in [RTW];
    logic [IW-1:0]  w_rad_in  [RTW];

    for (genvar s = 0; s < RTW; s++) begin : g_stage
        logic [RTW+3:0] w_cur;
        logic [RTW+3:0] w_trial;
        logic           w_ge;
        if (s == 0) begin : g_first
            assign w_rem_in[s]  = '0;
            assign w_root_in[s] = '0;
            assign w_rad_in[s]  = i_rad;
        end else begin : g_next
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_root_in[s] = r_root[s-1];
            assign w_rad_in[s]  = r_rad[s-1];
        end
        assign w_cur   = {w_rem_in[s], w_rad_in[s][IW-1:IW-2]};
        assign w_trial = (RTW+4)'({w_root_in[s], 2'b01});
        assign w_ge    = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (RTW+2)'(w_cur - w_trial) : (RTW+2)'(w_cur);
                r_root[s] <= {w_root_in[s][RTW-2:0], w_ge};
                r_rad[s]  <= w_rad_in[s] << 2;
            end
        end
    end

    assign o_root = r_root[RTW-1];
endmodule
`default_nettype wire
